### rtl/ptc_pkg.sv
// Package for the pitch trim controller: word types, register indexes, constants.
// No dependencies; used by ptc_cfg_if and every module under rtl.
`timescale 1ns / 1ps

package ptc_pkg;

  // register indexes on the configuration channel
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_SETPOINT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_TOLERANCE = 2'd2;

  localparam int unsigned CFG_DATA_W = 12;

  // action codes
  localparam logic ACT_TICK       = 1'b0;
  localparam logic ACT_IDLE_CHECK = 1'b1;

  // position and counter limits
  localparam logic signed [3:0] STEP_MAX   = 4'sd5;
  localparam logic signed [3:0] STEP_MIN   = -4'sd5;
  localparam logic signed [8:0] POS_MAX    = 9'sd100;
  localparam logic signed [8:0] POS_MIN    = -9'sd100;
  localparam logic [6:0]        IDLE_SAT   = 7'd100;
  localparam logic [6:0]        HOLD_OFF   = 7'd2;
  localparam logic [6:0]        IDLE_LIMIT = 7'd8;

  typedef struct packed {
    logic              hold_enable;
    logic signed [11:0] pitch_setpoint;
    logic [11:0]        pitch_tolerance;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic signed [11:0] pitch_sample;
  } in_word_t;

endpackage

### rtl/ptc_cfg_if.sv
// Configuration write channel for the pitch trim controller.
// Depends on ptc_pkg.
`timescale 1ns / 1ps

interface ptc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]   index;
  logic [ptc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ptc_in_if.sv
// Input word channel: action code and sine-of-pitch sample.
// No dependencies.
`timescale 1ns / 1ps

interface ptc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [11:0] pitch_sample;

  modport source (output valid, output action, output pitch_sample, input ready);
  modport sink   (input valid, input action, input pitch_sample, output ready);
endinterface

### rtl/ptc_out_if.sv
// Result word channel: actuator command and status.
// No dependencies.
`timescale 1ns / 1ps

interface ptc_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] mass_command;
  logic              command_issued;
  logic              stop_issued;
  logic [6:0]        idle_ticks;
  logic              actuator_stopped;

  modport source (output valid, output mass_command, output command_issued,
                  output stop_issued, output idle_ticks, output actuator_stopped,
                  input ready);
  modport sink   (input valid, input mass_command, input command_issued,
                  input stop_issued, input idle_ticks, input actuator_stopped,
                  output ready);
endinterface

### rtl/pitch_trim_controller.sv
// Pitch trim controller: slow pitch-trim regulator for a moving-mass actuator.
// Accepts one word per clock cycle while results are taken. Each word is held
// in an input register, and the core moves it into the result register once
// that register is free or being taken; the single update pass between
// those two registers sets the rate. A waiting result holds the core, so the
// input register keeps one further word and the input then stalls until the
// result is taken. Configuration writes are always ready and should be
// made only while the block is empty. No initialisation sweep after reset.
// Depends on ptc_pkg, the three channel interfaces, ptc_cfg_regs, ptc_in_reg
// and ptc_core.
`timescale 1ns / 1ps

module pitch_trim_controller (
  input logic        clk,
  input logic        rst,
  ptc_cfg_if.sink    cfg,
  ptc_in_if.sink     item,
  ptc_out_if.source  result
);

  ptc_pkg::cfg_t     regs;
  ptc_pkg::in_word_t word;
  logic              word_valid;
  logic              take;

  ptc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ptc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  ptc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .word_valid (word_valid),
    .word       (word),
    .take       (take),
    .result     (result)
  );

endmodule

### rtl/ptc_cfg_regs.sv
// Configuration register file for the pitch trim controller.
// Depends on ptc_pkg and ptc_cfg_if.
`timescale 1ns / 1ps

module ptc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ptc_cfg_if.sink       cfg,
  output ptc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ptc_pkg::REG_HOLD_ENABLE:     regs.hold_enable     <= cfg.data[0];
        ptc_pkg::REG_PITCH_SETPOINT:  regs.pitch_setpoint  <= $signed(cfg.data);
        ptc_pkg::REG_PITCH_TOLERANCE: regs.pitch_tolerance <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/ptc_in_reg.sv
// Input register stage: holds one accepted word until the core takes it.
// Depends on ptc_pkg and ptc_in_if.
`timescale 1ns / 1ps

module ptc_in_reg (
  input  logic              clk,
  input  logic              rst,
  ptc_in_if.sink            item,
  input  logic              take,
  output logic              word_valid,
  output ptc_pkg::in_word_t word
);

  assign item.ready = !word_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (item.ready) begin
      word_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      word.action       <= item.action;
      word.pitch_sample <= item.pitch_sample;
    end
  end

endmodule

### rtl/ptc_core.sv
// Trim core: actuator state, one-pass update logic and the result register.
// Depends on ptc_pkg and ptc_out_if.
`timescale 1ns / 1ps

module ptc_core (
  input  logic              clk,
  input  logic              rst,
  input  ptc_pkg::cfg_t     regs,
  input  logic              word_valid,
  input  ptc_pkg::in_word_t word,
  output logic              take,
  ptc_out_if.source         result
);

  logic signed [7:0] mass_position;
  logic [6:0]        idle_counter;
  logic              stopped_flag;

  logic signed [7:0] mass_position_next;
  logic [6:0]        idle_counter_next;
  logic              stopped_flag_next;

  logic              is_tick;
  logic [6:0]        cnt_inc;
  logic signed [12:0] err;
  logic [12:0]       mag;
  logic signed [12:0] quot;
  logic signed [8:0] q;
  logic signed [3:0] step;
  logic signed [8:0] sum;
  logic signed [7:0] pos_clamped;
  logic              fire;
  logic              stop;

  always_comb begin
    is_tick = (word.action == ptc_pkg::ACT_TICK);
    cnt_inc = (!stopped_flag && idle_counter < ptc_pkg::IDLE_SAT) ?
              idle_counter + 7'd1 : idle_counter;

    err  = {word.pitch_sample[11], word.pitch_sample} -
           {regs.pitch_setpoint[11], regs.pitch_setpoint};
    mag  = err[12] ? (~err + 13'd1) : err;
    // truncate toward zero
    quot = err[12] ? ((err + 13'sd15) >>> 4) : (err >>> 4);
    q    = quot[8:0];

    if (q > 9'sd5) begin
      step = ptc_pkg::STEP_MAX;
    end else if (q < -9'sd5) begin
      step = ptc_pkg::STEP_MIN;
    end else begin
      step = q[3:0];
    end

    sum = {mass_position[7], mass_position} + {{5{step[3]}}, step};
    if (sum > ptc_pkg::POS_MAX) begin
      pos_clamped = ptc_pkg::POS_MAX[7:0];
    end else if (sum < ptc_pkg::POS_MIN) begin
      pos_clamped = ptc_pkg::POS_MIN[7:0];
    end else begin
      pos_clamped = sum[7:0];
    end

    fire = is_tick && regs.hold_enable &&
           (stopped_flag || cnt_inc >= ptc_pkg::HOLD_OFF) &&
           (mag >= {1'b0, regs.pitch_tolerance}) && (q != 9'sd0);
    stop = !is_tick && !stopped_flag && (idle_counter > ptc_pkg::IDLE_LIMIT);

    mass_position_next = fire ? pos_clamped : mass_position;
    if (fire) begin
      idle_counter_next = '0;
      stopped_flag_next = 1'b0;
    end else if (stop) begin
      idle_counter_next = ptc_pkg::IDLE_SAT;
      stopped_flag_next = 1'b1;
    end else begin
      idle_counter_next = is_tick ? cnt_inc : idle_counter;
      stopped_flag_next = stopped_flag;
    end
  end

  assign take = word_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_position <= '0;
      idle_counter  <= '0;
      stopped_flag  <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (take) begin
        mass_position <= mass_position_next;
        idle_counter  <= idle_counter_next;
        stopped_flag  <= stopped_flag_next;
        result.valid  <= 1'b1;
      end else if (result.ready) begin
        result.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.mass_command     <= mass_position_next;
      result.command_issued   <= fire;
      result.stop_issued      <= stop;
      result.idle_ticks       <= idle_counter_next;
      result.actuator_stopped <= stopped_flag_next;
    end
  end

  a_cmd_stop_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.command_issued && result.stop_issued))
    else $error("command and stop in one word");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (mass_position <= 8'sd100) && (mass_position >= -8'sd100))
    else $error("position out of range");

  a_stopped_sat: assert property (@(posedge clk) disable iff (rst)
    stopped_flag |-> (idle_counter == ptc_pkg::IDLE_SAT))
    else $error("stopped without saturated idle count");

  a_cmd_clears: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.command_issued) |->
      (result.idle_ticks == 7'd0 && !result.actuator_stopped))
    else $error("command did not clear idle state");

  a_state_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> (result.mass_command == mass_position &&
              result.idle_ticks == idle_counter))
    else $error("result word disagrees with state");

endmodule

### tb/trim_checker.sv
// Scoreboard for the pitch trim controller: mirrors the register writes, predicts
// each result word from the accepted input words and compares field by field.
// Depends on ptc_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module trim_checker
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ptc_cfg_if          cfg,
  ptc_in_if           item,
  ptc_out_if          result,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  localparam int TRIM_DIV = 16;

  typedef struct packed {
    logic signed [7:0] mass_command;
    logic              command_issued;
    logic              stop_issued;
    logic [6:0]        idle_ticks;
    logic              actuator_stopped;
  } trim_result_t;

  // register mirror
  logic               hold_en;
  logic signed [11:0] setpoint;
  logic [11:0]        tolerance;

  // actuator state
  logic signed [7:0]  trim_pos;
  logic [6:0]         idle_cnt;
  logic               stopped;

  trim_result_t       expected_words[$];
  trim_result_t       want;

  function automatic trim_result_t advance_trim(input logic act,
                                                input logic signed [11:0] sample);
    int           err;
    int           mag;
    int           step;
    int           pos;
    trim_result_t r;
    r.command_issued = 1'b0;
    r.stop_issued    = 1'b0;
    if (act == ACT_TICK) begin
      if (!stopped && idle_cnt < IDLE_SAT) idle_cnt = idle_cnt + 7'd1;
      if (hold_en && (stopped || idle_cnt >= HOLD_OFF)) begin
        err  = int'(sample) - int'(setpoint);
        mag  = (err < 0) ? -err : err;
        step = err / TRIM_DIV;
        if (mag >= int'(tolerance) && step != 0) begin
          if (step > int'(STEP_MAX)) step = int'(STEP_MAX);
          if (step < int'(STEP_MIN)) step = int'(STEP_MIN);
          pos = int'(trim_pos) + step;
          if (pos > int'(POS_MAX)) pos = int'(POS_MAX);
          if (pos < int'(POS_MIN)) pos = int'(POS_MIN);
          trim_pos         = pos[7:0];
          idle_cnt         = '0;
          stopped          = 1'b0;
          r.command_issued = 1'b1;
        end
      end
    end else begin
      // a check while already stopped leaves everything alone
      if (!stopped && idle_cnt > IDLE_LIMIT) begin
        stopped       = 1'b1;
        idle_cnt      = IDLE_SAT;
        r.stop_issued = 1'b1;
      end
    end
    r.mass_command     = trim_pos;
    r.idle_ticks       = idle_cnt;
    r.actuator_stopped = stopped;
    return r;
  endfunction

  task automatic check_field(input string field, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_en   = 1'b0;
      setpoint  = '0;
      tolerance = '0;
      trim_pos  = '0;
      idle_cnt  = '0;
      stopped   = 1'b0;
      expected_words.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("mass_command", int'(want.mass_command), int'(result.mass_command));
          check_field("command_issued", int'(want.command_issued),
                      int'(result.command_issued));
          check_field("stop_issued", int'(want.stop_issued), int'(result.stop_issued));
          check_field("idle_ticks", int'(want.idle_ticks), int'(result.idle_ticks));
          check_field("actuator_stopped", int'(want.actuator_stopped),
                      int'(result.actuator_stopped));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_HOLD_ENABLE:     hold_en   = cfg.data[0];
          REG_PITCH_SETPOINT:  setpoint  = cfg.data;
          REG_PITCH_TOLERANCE: tolerance = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        expected_words.push_back(advance_trim(item.action, item.pitch_sample));
      outstanding = expected_words.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the pitch trim controller regression: clock, reset, register settings,
// directed and random input words, random back-pressure and the verdict.
// Depends on ptc_pkg, the channel interfaces, pitch_trim_controller and trim_checker.
`timescale 1ns / 1ps

module testbench;
  import ptc_pkg::*;

  localparam int unsigned LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned words_taken = 0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;
  int          cur_sp = 0;

  ptc_cfg_if cfg_ch ();
  ptc_in_if  in_ch ();
  ptc_out_if out_ch ();

  pitch_trim_controller dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (in_ch),
    .result (out_ch)
  );

  trim_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .item        (in_ch),
    .result      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("pitch_trim_controller regression: fail");
    $finish;
  end

  task automatic send_word(input logic act, input int smp_val);
    int unsigned gap;
    if (words_sent % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    gap = calm_tx ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.pitch_sample <= smp_val[11:0];
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
  endtask

  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input bit hold, input int sp, input int tol);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx = '{REG_HOLD_ENABLE, REG_PITCH_SETPOINT, REG_PITCH_TOLERANCE};
    // spare bits of the enable word are noise
    val = '{{11'($urandom), hold}, sp[11:0], tol[11:0]};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    end
    cfg_ch.valid <= 1'b0;
    cur_sp = int'($signed(sp[11:0]));
  endtask

  // disturbance runs push the mass towards a limit; settle runs then idle it out
  task automatic random_phase(input int unsigned n_words);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    int          dir;
    target = words_sent + n_words;
    while (words_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        len = $urandom_range(6, 40);
        dir = $urandom_range(0, 1) ? 1 : -1;
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) send_word(ACT_IDLE_CHECK, int'($urandom));
          else send_word(ACT_TICK, cur_sp + dir * int'($urandom_range(0, 1100)));
        end
      end else if (kind <= 7) begin
        len = $urandom_range(6, 15);
        repeat (len) send_word(ACT_TICK, cur_sp + int'($urandom_range(0, 30)) - 15);
        repeat ($urandom_range(1, 2)) send_word(ACT_IDLE_CHECK, int'($urandom));
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) send_word(logic'($urandom_range(0, 1)), int'($urandom));
      end
    end
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (words_taken % 40 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      gap = calm_rx ? 0 : $urandom_range(0, 17);
      if (words_taken == 300) gap = 400;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      words_taken++;
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_HOLD_ENABLE;
    cfg_ch.data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.pitch_sample <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // holding off at reset: counter runs, early idle check does nothing
    send_word(ACT_TICK, 1024);
    send_word(ACT_TICK, -1024);
    send_word(ACT_IDLE_CHECK, 0);
    wait_empty();

    apply_setting(1'b1, 0, 0);
    send_word(ACT_TICK, 2047);
    send_word(ACT_TICK, -2048);
    send_word(ACT_TICK, 1024);
    send_word(ACT_TICK, -1024);
    send_word(ACT_TICK, 15);
    send_word(ACT_TICK, -15);
    send_word(ACT_TICK, 16);
    send_word(ACT_TICK, -16);
    send_word(ACT_TICK, -16);
    send_word(ACT_TICK, 0);
    repeat (9) send_word(ACT_TICK, 0);
    send_word(ACT_IDLE_CHECK, 0);
    send_word(ACT_IDLE_CHECK, 0);
    send_word(ACT_TICK, 1024);
    wait_empty();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(1'b1, -1024, 0);
        1: apply_setting(1'b1, 1024, 2048);
        2: apply_setting(1'b0, 0, 0);
        3: apply_setting(1'b1, 2047, 4095);
        4: apply_setting(1'b1, -2048, 31);
        default: apply_setting($urandom_range(0, 7) != 0,
                               int'($urandom_range(0, 2048)) - 1024,
                               int'($urandom_range(0, 64)));
      endcase
      random_phase(125);
      wait_empty();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("pitch_trim_controller regression: pass");
    else
      $display("pitch_trim_controller regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/ptc_pkg.sv
rtl/ptc_cfg_if.sv
rtl/ptc_in_if.sv
rtl/ptc_out_if.sv
rtl/ptc_cfg_regs.sv
rtl/ptc_in_reg.sv
rtl/ptc_core.sv
rtl/pitch_trim_controller.sv
tb/trim_checker.sv
tb/testbench.sv
